>>> rtl/tadd_pkg.sv
// tadd_pkg: shared types, constants and shift adaptation tables of the
// tablet adaptive delta decoder. No dependencies.

package tadd_pkg;

    // default parameter values
    localparam int TOOLS_DEF     = 2;
    localparam int SHIFT_MAX_DEF = 15;
    localparam int CHANNELS      = 7;

    // channel codes
    localparam logic [2:0] CH_LOC_X  = 3'd0;
    localparam logic [2:0] CH_LOC_Y  = 3'd1;
    localparam logic [2:0] CH_TILT_X = 3'd2;
    localparam logic [2:0] CH_TILT_Y = 3'd3;
    localparam logic [2:0] CH_PRESS  = 3'd4;
    localparam logic [2:0] CH_Z      = 3'd5;
    localparam logic [2:0] CH_ROT    = 3'd6;
    localparam logic [2:0] CH_UNUSED = 3'd7;

    // action codes
    localparam logic ACT_DELTA = 1'b0;
    localparam logic ACT_LOAD  = 1'b1;

    // register indexes (byte address bit 2)
    localparam logic REG_MAX_X = 1'b0;
    localparam logic REG_MAX_Y = 1'b1;

    // clamp and hold constants
    localparam logic [6:0]  PRESS_BIG = 7'h40;
    localparam logic [15:0] PRESS_MAX = 16'h03ff;
    localparam logic [15:0] TILT_MAX  = 16'h007f;
    localparam logic [15:0] ROT_MAX   = 16'h0e0e;
    localparam logic [15:0] HOLD_VAL  = 16'h0009;
    localparam logic [3:0]  HOLD_CODE = 4'hf;

    typedef logic signed [2:0] shift_chg_t;

    // one input transaction
    typedef struct packed {
        logic        action;
        logic        tool;
        logic [2:0]  channel;
        logic [4:0]  raw_code;
        logic [15:0] load_value;
        logic [3:0]  load_shift;
    } item_t;

    // per-channel stored state
    typedef struct packed {
        logic [15:0] raw;
        logic [3:0]  shift;
        logic        hold;
    } entry_t;

    // one result transaction
    typedef struct packed {
        logic [15:0] value;
        logic [3:0]  step_out;
        logic        held;
    } result_t;

    // location: zero -2, small -1, large none, max +2
    function automatic shift_chg_t loc_change(input logic [3:0] mag);
        shift_chg_t chg;
        if (mag == 4'd0)
            chg = -3'sd2;
        else if (mag <= 4'd7)
            chg = -3'sd1;
        else if (mag == 4'd15)
            chg = 3'sd2;
        else
            chg = 3'sd0;
        return chg;
    endfunction

    // tilt, pressure and z
    function automatic shift_chg_t tilt_change(input logic [2:0] mag);
        shift_chg_t chg;
        case (mag)
            3'd0:    chg = -3'sd3;
            3'd1:    chg = -3'sd2;
            3'd2:    chg = -3'sd1;
            3'd3:    chg = -3'sd1;
            3'd6:    chg = 3'sd1;
            3'd7:    chg = 3'sd2;
            default: chg = 3'sd0;
        endcase
        return chg;
    endfunction

    // rotation
    function automatic shift_chg_t rot_change(input logic [1:0] mag);
        shift_chg_t chg;
        case (mag)
            2'd0:    chg = -3'sd1;
            2'd2:    chg = 3'sd1;
            2'd3:    chg = 3'sd2;
            default: chg = 3'sd0;
        endcase
        return chg;
    endfunction

endpackage

>>> rtl/tadd_if.sv
// tadd_in_if and tadd_out_if: valid/ready channels of the decoder.
// Depends on nothing.

interface tadd_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic        tool;
    logic [2:0]  channel;
    logic [4:0]  raw_code;
    logic [15:0] load_value;
    logic [3:0]  load_shift;

    modport source (output valid, action, tool, channel, raw_code, load_value,
                    load_shift, input ready);
    modport sink   (input valid, action, tool, channel, raw_code, load_value,
                    load_shift, output ready);
endinterface

interface tadd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;
    logic [3:0]  step_out;
    logic        held;

    modport source (output valid, value, step_out, held, input ready);
    modport sink   (input valid, value, step_out, held, output ready);
endinterface

>>> rtl/tablet_adaptive_delta_decoder_unit.sv
// tablet_adaptive_delta_decoder_unit: top level with channel state memory,
// forwarding, output register and APB register port.
// Depends on tadd_pkg, tadd_if (tadd_in_if, tadd_out_if) and tadd_update.

// Usage
// din carries one code or load per transaction; dout returns exactly one
// result per transaction, in order. A transaction is taken when valid and
// ready are both high at a rising edge of clk.
// The state memory is read at the edge that takes the input transaction,
// into the stage 1 registers; the result is computed from them and
// registered in the output register once that register is free, which
// raises dout.valid. Throughput is one transaction per cycle while dout
// does not stall; the read-modify-write of a channel entry is covered by
// forwarding the most recent write, so codes for the same channel may follow
// back to back.
// When dout stalls, the output register and the compute stage fill, and
// din.ready drops only once both hold a transaction.
// Reset (rst_n low, asynchronous) clears the per-entry valid bits, so every
// channel reads as value 0, shift 0, hold 0 at once; there is no clearing
// pass. max_x and max_y return to 0xffff. The user writes them over APB at
// byte addresses 0 and 4 only while the block is idle; it does not check.

module tablet_adaptive_delta_decoder_unit
    import tadd_pkg::*;
#(
    parameter int TOOLS     = TOOLS_DEF,
    parameter int SHIFT_MAX = SHIFT_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tadd_in_if.sink     din,
    tadd_out_if.source  dout,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH   = TOOLS * CHANNELS;
    localparam int ENTRY_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [15:0] max_x_reg, max_y_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MAX_Y) ? {16'd0, max_y_reg} : {16'd0, max_x_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= 16'hffff;
            max_y_reg <= 16'hffff;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_MAX_X)
                max_x_reg <= pwdata[15:0];
            else
                max_y_reg <= pwdata[15:0];
        end
    end

    // input decode
    item_t              in_item;
    logic               in_ok;
    logic [ENTRY_W-1:0] in_entry;
    logic               in_acc;

    assign in_item  = '{action: din.action, tool: din.tool, channel: din.channel,
                        raw_code: din.raw_code, load_value: din.load_value,
                        load_shift: din.load_shift};
    assign in_ok    = (din.channel != CH_UNUSED) && (32'(din.tool) < TOOLS);
    assign in_entry = ENTRY_W'(din.tool) * ENTRY_W'(CHANNELS) + ENTRY_W'(din.channel);
    assign in_acc   = din.valid && din.ready;

    // pipeline control
    logic s1_valid_reg, s1_ok_reg, out_valid_reg;
    logic out_free, s1_adv;

    assign out_free   = !out_valid_reg || dout.ready;
    assign s1_adv     = s1_valid_reg && out_free;
    assign din.ready  = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (din.ready)
            begin
                s1_valid_reg <= din.valid;
                s1_ok_reg    <= din.valid && in_ok;
            end
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // stage 1 payload
    item_t              s1_item_reg;
    logic [ENTRY_W-1:0] s1_entry_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_item_reg  <= in_item;
            s1_entry_reg <= in_entry;
        end
    end

    // channel state memory, read-before-write
    entry_t             mem [DEPTH];
    entry_t             rd_data_reg;
    logic [DEPTH-1:0]   vld_reg;
    logic               rd_vld_reg;
    logic               rd_en, wr_en;
    entry_t             wr_data;

    assign rd_en = in_acc && in_ok;
    assign wr_en = s1_adv && s1_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_entry_reg] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[in_entry];
    end

    // valid bits stand in for the zero reset of the memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                vld_reg[s1_entry_reg] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= vld_reg[in_entry];
        end
    end

    // forwarding of the most recent write
    logic               byp_valid_reg;
    logic [ENTRY_W-1:0] byp_entry_reg;
    entry_t             byp_data_reg;
    entry_t             cur_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_valid_reg <= 1'b0;
        else if (wr_en)
            byp_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_entry_reg <= s1_entry_reg;
            byp_data_reg  <= wr_data;
        end
    end

    always_comb
    begin
        if (byp_valid_reg && (byp_entry_reg == s1_entry_reg))
            cur_entry = byp_data_reg;
        else if (rd_vld_reg)
            cur_entry = rd_data_reg;
        else
            cur_entry = '0;
    end

    // entry update
    result_t upd_res;

    tadd_update #(
        .SHIFT_MAX (SHIFT_MAX)
    ) u_update (
        .item  (s1_item_reg),
        .cur   (cur_entry),
        .max_x (max_x_reg),
        .max_y (max_y_reg),
        .nxt   (wr_data),
        .res   (upd_res)
    );

    // output register
    result_t out_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            out_reg <= s1_ok_reg ? upd_res : '0;
    end

    assign dout.valid    = out_valid_reg;
    assign dout.value    = out_reg.value;
    assign dout.step_out = out_reg.step_out;
    assign dout.held     = out_reg.held;

`ifndef NO_ASSERTIONS
    // input stalls only when both stages are occupied and the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !din.ready |-> (s1_valid_reg && out_valid_reg && !dout.ready))
    else $error("input stalled with room in the pipeline");

    // every state write is kept for forwarding and marks its entry valid
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (byp_valid_reg && byp_entry_reg == $past(s1_entry_reg)
                   && vld_reg[$past(s1_entry_reg)]))
    else $error("forwarding register lost the last write");

    // hold flag is only ever set on pressure or z entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_data.hold) |->
            (s1_item_reg.channel == CH_PRESS || s1_item_reg.channel == CH_Z))
    else $error("hold flag written on a channel without hold");

    // reported step shift never exceeds the saturation limit
    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> (dout.step_out <= 4'(SHIFT_MAX)))
    else $error("step shift above limit");
`endif

endmodule

>>> rtl/tadd_update.sv
// tadd_update: next state and result of one channel entry for one transaction.
// Depends on tadd_pkg.

module tadd_update
    import tadd_pkg::*;
#(
    parameter int SHIFT_MAX = SHIFT_MAX_DEF
) (
    input  item_t       item,
    input  entry_t      cur,
    input  logic [15:0] max_x,
    input  logic [15:0] max_y,
    output entry_t      nxt,
    output result_t     res
);

    localparam int DW = 23;   // 0x40 << 15
    localparam int SW = 25;   // signed sum of raw and delta

    logic                 is_loc, is_tilt, is_press, is_rot;
    logic [3:0]           mag;
    logic                 neg;
    logic                 big;
    logic [6:0]           base;
    logic [DW-1:0]        delta;
    logic signed [SW-1:0] sum, sum_p;
    logic                 pin, hold_n;
    logic [15:0]          hi, clamped;
    logic [15:0]          rot_w, rot_v;
    shift_chg_t           chg;
    logic signed [5:0]    sh_sum;
    logic [3:0]           sh_adapt, sh_load;
    logic [16:0]          avg_sum;
    logic [15:0]          raw_n;

    // channel kind, sign and magnitude
    always_comb
    begin
        is_loc   = 1'b0;
        is_tilt  = 1'b0;
        is_press = 1'b0;
        is_rot   = 1'b0;
        mag      = {1'b0, item.raw_code[2:0]};
        neg      = item.raw_code[3];
        case (item.channel)
            CH_LOC_X, CH_LOC_Y:
            begin
                is_loc = 1'b1;
                mag    = item.raw_code[3:0];
                neg    = item.raw_code[4];
            end
            CH_TILT_X, CH_TILT_Y:
                is_tilt = 1'b1;
            CH_PRESS, CH_Z:
                is_press = 1'b1;
            CH_ROT:
            begin
                is_rot = 1'b1;
                mag    = {2'b00, item.raw_code[1:0]};
                neg    = item.raw_code[2];
            end
            default:
                is_tilt = 1'b0;
        endcase
    end

    // scaled step and full-width sum
    assign big   = is_press && (mag == 4'd7);
    assign base  = big ? PRESS_BIG : {3'b000, mag};
    assign delta = DW'(base) << cur.shift;
    assign sum   = neg ? $signed({9'b0, cur.raw}) - $signed({2'b0, delta})
                       : $signed({9'b0, cur.raw}) + $signed({2'b0, delta});

    // pressure and z hold handling
    always_comb
    begin
        pin    = 1'b0;
        hold_n = cur.hold;
        if (is_press)
        begin
            if (cur.hold)
            begin
                if (neg)
                    pin = 1'b1;
                else
                    hold_n = 1'b0;
            end
            else if (item.raw_code[3:0] == HOLD_CODE)
            begin
                pin    = 1'b1;
                hold_n = 1'b1;
            end
        end
    end

    assign sum_p = pin ? $signed({9'b0, HOLD_VAL}) : sum;

    // clamp per kind
    always_comb
    begin
        if (is_loc)
            hi = (item.channel == CH_LOC_X) ? max_x : max_y;
        else if (is_tilt)
            hi = TILT_MAX;
        else
            hi = PRESS_MAX;
        if (sum_p < 0)
            clamped = 16'd0;
        else if (sum_p > $signed({9'b0, hi}))
            clamped = hi;
        else
            clamped = sum_p[15:0];
    end

    // rotation wraps then clamps
    assign rot_w = neg ? cur.raw - delta[15:0] : cur.raw + delta[15:0];
    assign rot_v = (rot_w > ROT_MAX) ? ROT_MAX : rot_w;

    // shift adaptation, saturating
    always_comb
    begin
        if (is_loc)
            chg = loc_change(mag);
        else if (is_rot)
            chg = rot_change(mag[1:0]);
        else if (big)
            chg = 3'sd0;
        else
            chg = tilt_change(mag[2:0]);
        sh_sum = $signed({2'b00, cur.shift}) + 6'(chg);
        if (sh_sum < 0)
            sh_adapt = 4'd0;
        else if (sh_sum > $signed(6'(SHIFT_MAX)))
            sh_adapt = 4'(SHIFT_MAX);
        else
            sh_adapt = sh_sum[3:0];
        sh_load = (item.load_shift > 4'(SHIFT_MAX)) ? 4'(SHIFT_MAX) : item.load_shift;
    end

    // location reports the mean of new and previous raw values
    assign avg_sum = {1'b0, clamped} + {1'b0, cur.raw};
    assign raw_n   = is_rot ? rot_v : clamped;

    always_comb
    begin
        if (item.action == ACT_LOAD)
        begin
            nxt.raw   = item.load_value;
            nxt.shift = sh_load;
            nxt.hold  = cur.hold;
            res.value = item.load_value;
        end
        else
        begin
            nxt.raw   = raw_n;
            nxt.shift = sh_adapt;
            nxt.hold  = hold_n;
            res.value = is_loc ? avg_sum[16:1] : raw_n;
        end
        res.step_out = nxt.shift;
        res.held     = nxt.hold;
    end

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench of the tablet adaptive delta decoder unit.
// Depends on tadd_pkg, tadd_if (tadd_in_if, tadd_out_if) and the decoder RTL.

module tb_top;
    import tadd_pkg::*;

    // tracks per-channel decode state and the results still due from the block
    class decode_tracker;
        logic [15:0] raw_mem   [0:13];
        logic [15:0] shown_mem [0:13];
        logic [3:0]  shift_mem [0:13];
        logic        hold_mem  [0:13];
        logic [15:0] lim_x;
        logic [15:0] lim_y;
        result_t     due_results [$];
        int          errors;

        function new();
            for (int i = 0; i < 14; i++)
            begin
                raw_mem[i]   = '0;
                shown_mem[i] = '0;
                shift_mem[i] = '0;
                hold_mem[i]  = 1'b0;
            end
            lim_x  = 16'hffff;
            lim_y  = 16'hffff;
            errors = 0;
        endfunction

        function void set_limit(input logic idx, input logic [15:0] v);
            if (idx == REG_MAX_X)
                lim_x = v;
            else
                lim_y = v;
        endfunction

        function logic [3:0] adapt_shift(input int sh, input int chg);
            int s;
            s = sh + chg;
            if (s < 0)
                s = 0;
            if (s > SHIFT_MAX_DEF)
                s = SHIFT_MAX_DEF;
            return s[3:0];
        endfunction

        function int clamp_to(input int v, input int hi);
            if (v < 0)
                return 0;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int tilt_adj(input int mag);
            case (mag)
                0:       return -3;
                1:       return -2;
                2, 3:    return -1;
                6:       return 1;
                7:       return 2;
                default: return 0;
            endcase
        endfunction

        // work out the result of one accepted transaction and queue it
        function void note_item(input item_t it);
            result_t     exp;
            int          e;
            int          sh;
            int          mag;
            int          delta;
            int          sum;
            int          nv;
            int          old;
            logic        neg;
            logic [15:0] d;
            logic [15:0] w;
            exp = '0;
            if (it.channel != CH_UNUSED)
            begin
                e  = int'(it.tool) * CHANNELS + int'(it.channel);
                sh = int'(shift_mem[e]);
                old = int'(raw_mem[e]);
                if (it.action == ACT_LOAD)
                begin
                    raw_mem[e]   = it.load_value;
                    shown_mem[e] = it.load_value;
                    shift_mem[e] = it.load_shift;
                end
                else
                begin
                    case (it.channel)
                        CH_LOC_X, CH_LOC_Y:
                        begin
                            mag   = int'(it.raw_code[3:0]);
                            neg   = it.raw_code[4];
                            delta = mag << sh;
                            sum   = neg ? old - delta : old + delta;
                            if (mag == 0)
                                shift_mem[e] = adapt_shift(sh, -2);
                            else if (mag <= 7)
                                shift_mem[e] = adapt_shift(sh, -1);
                            else if (mag == 15)
                                shift_mem[e] = adapt_shift(sh, 2);
                            else
                                shift_mem[e] = adapt_shift(sh, 0);
                            nv = clamp_to(sum, (it.channel == CH_LOC_X) ? int'(lim_x)
                                                                        : int'(lim_y));
                            shown_mem[e] = 16'((nv + old) >> 1);
                            raw_mem[e]   = 16'(nv);
                        end
                        CH_TILT_X, CH_TILT_Y, CH_PRESS, CH_Z:
                        begin
                            mag = int'(it.raw_code[2:0]);
                            neg = it.raw_code[3];
                            // pressure and z treat the top magnitude as a big step
                            if ((it.channel == CH_PRESS || it.channel == CH_Z) && mag == 7)
                            begin
                                delta        = int'(PRESS_BIG) << sh;
                                shift_mem[e] = adapt_shift(sh, 0);
                            end
                            else
                            begin
                                delta        = mag << sh;
                                shift_mem[e] = adapt_shift(sh, tilt_adj(mag));
                            end
                            sum = neg ? old - delta : old + delta;
                            if (it.channel == CH_TILT_X || it.channel == CH_TILT_Y)
                                nv = clamp_to(sum, int'(TILT_MAX));
                            else
                            begin
                                // hold pins the value before the clamp
                                if (hold_mem[e])
                                begin
                                    if (neg)
                                        sum = int'(HOLD_VAL);
                                    else
                                        hold_mem[e] = 1'b0;
                                end
                                else if (it.raw_code[3:0] == HOLD_CODE)
                                begin
                                    sum         = int'(HOLD_VAL);
                                    hold_mem[e] = 1'b1;
                                end
                                nv = clamp_to(sum, int'(PRESS_MAX));
                            end
                            raw_mem[e]   = 16'(nv);
                            shown_mem[e] = 16'(nv);
                        end
                        default:
                        begin
                            // rotation wraps in 16 bits, then clamps
                            mag = int'(it.raw_code[1:0]);
                            neg = it.raw_code[2];
                            d   = 16'(mag << sh);
                            w   = neg ? raw_mem[e] - d : raw_mem[e] + d;
                            if (w > ROT_MAX)
                                w = ROT_MAX;
                            shift_mem[e] = adapt_shift(sh, mag - 1);
                            raw_mem[e]   = w;
                            shown_mem[e] = w;
                        end
                    endcase
                end
                exp.value    = shown_mem[e];
                exp.step_out = shift_mem[e];
                exp.held     = hold_mem[e];
            end
            due_results.push_back(exp);
        endfunction

        task report(input string msg);
            $display("%0t: error: %s", $time, msg);
            errors++;
        endtask

        // compare one accepted result with the oldest one due
        task check_result(input result_t got);
            result_t exp;
            if (due_results.size() == 0)
                report($sformatf("result with nothing due: value %h", got.value));
            else
            begin
                exp = due_results.pop_front();
                if (got.value !== exp.value)
                    report($sformatf("value %h, want %h", got.value, exp.value));
                if (got.step_out !== exp.step_out)
                    report($sformatf("step_out %h, want %h", got.step_out, exp.step_out));
                if (got.held !== exp.held)
                    report($sformatf("held %b, want %b", got.held, exp.held));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        calm;

    decode_tracker sb;

    tadd_in_if  din_if ();
    tadd_out_if dout_if ();

    tablet_adaptive_delta_decoder_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_if),
        .dout    (dout_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side stalls at random except in calm phases
    always @(negedge clk)
        dout_if.ready <= calm || ($urandom_range(0, 99) >= 38);

    // result monitor
    always @(posedge clk)
    begin : result_mon
        result_t got;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            got.value    = dout_if.value;
            got.step_out = dout_if.step_out;
            got.held     = dout_if.held;
            sb.check_result(got);
        end
    end

    // send one transaction, starting and ending at a falling edge
    task automatic send_item(input item_t it);
        while (!calm && $urandom_range(0, 99) < 38)
        begin
            din_if.valid = 1'b0;
            @(negedge clk);
        end
        din_if.valid      = 1'b1;
        din_if.action     = it.action;
        din_if.tool       = it.tool;
        din_if.channel    = it.channel;
        din_if.raw_code   = it.raw_code;
        din_if.load_value = it.load_value;
        din_if.load_shift = it.load_shift;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        sb.note_item(it);
        @(negedge clk);
        din_if.valid = 1'b0;
    endtask

    task automatic send_fields(input logic act, input logic tl, input logic [2:0] ch,
                               input logic [4:0] code, input logic [15:0] lval,
                               input logic [3:0] lsh);
        item_t it;
        it.action     = act;
        it.tool       = tl;
        it.channel    = ch;
        it.raw_code   = code;
        it.load_value = lval;
        it.load_shift = lsh;
        send_item(it);
    endtask

    // mostly valid channels and deltas, biased toward largest magnitudes
    task automatic send_random();
        item_t it;
        it.action     = ($urandom_range(0, 99) < 12) ? ACT_LOAD : ACT_DELTA;
        it.tool       = 1'($urandom_range(0, 1));
        it.channel    = ($urandom_range(0, 99) < 5) ? CH_UNUSED : 3'($urandom_range(0, 6));
        it.raw_code   = ($urandom_range(0, 3) == 0) ? {1'($urandom_range(0, 1)), 4'hf}
                                                    : 5'($urandom_range(0, 31));
        it.load_value = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1023))
                                                    : 16'($urandom);
        it.load_shift = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(0, 6));
        send_item(it);
    endtask

    // register write with setup and access phases
    task automatic apb_write(input logic idx, input logic [15:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'h0000, v};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_limit(idx, v);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // wait until every due result has come, then let the pipeline settle
    task automatic drain();
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    // run limit
    initial
    begin
        #(8 * 300000);
        $display("tablet_adaptive_delta_decoder_unit: mismatch");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [15:0] lx;
        logic [15:0] ly;
        sb = new();
        clk               = 1'b0;
        rst_n             = 1'b0;
        calm              = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        dout_if.ready     = 1'b0;
        din_if.valid      = 1'b0;
        din_if.action     = ACT_DELTA;
        din_if.tool       = 1'b0;
        din_if.channel    = CH_LOC_X;
        din_if.raw_code   = '0;
        din_if.load_value = '0;
        din_if.load_shift = '0;
        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // location: clamp at zero, largest step, clamp at the top, shift saturation
        send_fields(ACT_DELTA, 1'b0, CH_LOC_X, 5'h1f, 16'h0000, 4'h0);
        send_fields(ACT_DELTA, 1'b0, CH_LOC_X, 5'h0f, 16'hffff, 4'hf);
        send_fields(ACT_LOAD, 1'b1, CH_LOC_Y, 5'h00, 16'hffff, 4'hf);
        send_fields(ACT_DELTA, 1'b1, CH_LOC_Y, 5'h0f, 16'h0000, 4'h0);
        send_fields(ACT_DELTA, 1'b1, CH_LOC_Y, 5'h10, 16'h0000, 4'h0);
        send_fields(ACT_LOAD, 1'b0, CH_LOC_X, 5'h1f, 16'h8000, 4'hf);
        send_fields(ACT_DELTA, 1'b0, CH_LOC_X, 5'h1f, 16'h0000, 4'h0);
        // tilt: clamp at 0x7f and at zero, shift floor
        send_fields(ACT_LOAD, 1'b0, CH_TILT_X, 5'h00, 16'h007f, 4'h0);
        send_fields(ACT_DELTA, 1'b0, CH_TILT_X, 5'h07, 16'h0000, 4'h0);
        send_fields(ACT_DELTA, 1'b1, CH_TILT_Y, 5'h08, 16'h0000, 4'h0);
        // pressure hold: set, pin on negative, release on positive, big step
        send_fields(ACT_DELTA, 1'b0, CH_PRESS, 5'h0f, 16'h0000, 4'h0);
        send_fields(ACT_DELTA, 1'b0, CH_PRESS, 5'h0b, 16'h0000, 4'h0);
        send_fields(ACT_DELTA, 1'b0, CH_PRESS, 5'h03, 16'h0000, 4'h0);
        send_fields(ACT_DELTA, 1'b0, CH_PRESS, 5'h07, 16'h0000, 4'h0);
        // z: clamp at 0x3ff with ignored upper bit, then hold code
        send_fields(ACT_LOAD, 1'b1, CH_Z, 5'h00, 16'h03ff, 4'hf);
        send_fields(ACT_DELTA, 1'b1, CH_Z, 5'h17, 16'h0000, 4'h0);
        send_fields(ACT_DELTA, 1'b1, CH_Z, 5'h1f, 16'h0000, 4'h0);
        // rotation: wrap upward, wrap downward into the clamp, ignored upper bits
        send_fields(ACT_LOAD, 1'b0, CH_ROT, 5'h00, 16'hffff, 4'h0);
        send_fields(ACT_DELTA, 1'b0, CH_ROT, 5'h03, 16'h0000, 4'h0);
        send_fields(ACT_DELTA, 1'b0, CH_ROT, 5'h07, 16'h0000, 4'h0);
        send_fields(ACT_DELTA, 1'b0, CH_ROT, 5'h18, 16'h0000, 4'h0);
        // unused channel leaves state alone
        send_fields(ACT_LOAD, 1'b1, CH_UNUSED, 5'h1f, 16'hffff, 4'hf);
        drain();

        // zero location limits
        apb_write(REG_MAX_X, 16'h0000);
        apb_write(REG_MAX_Y, 16'h0000);
        send_fields(ACT_DELTA, 1'b0, CH_LOC_X, 5'h0f, 16'h0000, 4'h0);
        send_fields(ACT_LOAD, 1'b1, CH_LOC_Y, 5'h00, 16'h1234, 4'h3);
        send_fields(ACT_DELTA, 1'b1, CH_LOC_Y, 5'h01, 16'h0000, 4'h0);
        drain();

        // random phases, each with its own location limits
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    lx = 16'h00ff;
                    ly = 16'h1000;
                end
                2:
                begin
                    lx = 16'hffff;
                    ly = 16'hffff;
                end
                3:
                begin
                    lx = 16'($urandom_range(0, 255));
                    ly = 16'($urandom_range(0, 255));
                end
                default:
                begin
                    lx = 16'($urandom);
                    ly = 16'($urandom);
                end
            endcase
            apb_write(REG_MAX_X, lx);
            apb_write(REG_MAX_Y, ly);
            calm = (ph == 2);
            repeat (150)
                send_random();
            drain();
        end
        calm = 1'b0;

        repeat (8)
            @(negedge clk);
        if (sb.due_results.size() != 0)
            sb.report($sformatf("%0d results never came", sb.due_results.size()));
        if (sb.errors == 0)
            $display("tablet_adaptive_delta_decoder_unit: match");
        else
            $display("tablet_adaptive_delta_decoder_unit: mismatch");
        $finish;
    end

endmodule
